FILE: rtl/sss_pkg.sv
// Shared types and constants for the staggered start sequencer.
// No dependencies; used by staggered_start_sequencer.
`default_nettype none

package sss_pkg;

  // Field widths
  localparam int DUR_W    = 24;
  localparam int DELAY_W  = 16;
  localparam int ROTOR_W  = 3;
  localparam int PHASE_W  = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 1;

  // Default table depth
  localparam int ROTOR_COUNT_DEF = 8;

  // Register reset values
  localparam logic [DUR_W-1:0] ACTIVE_DUR_RST = 24'd10000;
  localparam logic [DUR_W-1:0] PAUSE_DUR_RST  = 24'd5000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DUR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_DUR  = 1'b1;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_OFF          = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DEACT        = 3'd1;
  localparam logic [PHASE_W-1:0] PH_START_ACTIVE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ACTIVE       = 3'd3;
  localparam logic [PHASE_W-1:0] PH_START_PAUSE  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PAUSE        = 3'd5;

  // Message kinds
  localparam logic [KIND_W-1:0] KIND_OFF    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CONFIG = 2'd3;

  // One result beat
  typedef struct packed {
    logic               msg_valid;
    logic [KIND_W-1:0]  msg_kind;
    logic               msg_broadcast;
    logic [ROTOR_W-1:0] msg_rotor;
    logic               led_on;
    logic [PHASE_W-1:0] phase_now;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/staggered_start_sequencer.sv
// Staggered start sequencer: an accepted input beat's result is registered in the output register,
// or in the skid register while the output register is full and stalled. Throughput is one beat per
// cycle while the skid is empty; the phase update is a combinational read-modify-write and the delay
// table entry for the next cursor value is prefetched. A two-deep output stage (register plus skid)
// takes one more input beat while a result waits. Reset is synchronous, active low; per-entry valid
// bits make unwritten delay table entries read as zero. Depends on sss_pkg.
`default_nettype none

module staggered_start_sequencer #(
  parameter int ROTOR_COUNT = sss_pkg::ROTOR_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sss_pkg::DUR_W-1:0]        cfg_wdata,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_op,
  input  wire logic                             in_switch_on,
  input  wire logic [sss_pkg::ROTOR_W-1:0]      in_delay_index,
  input  wire logic [sss_pkg::DELAY_W-1:0]      in_delay_value,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_msg_valid,
  output logic [sss_pkg::KIND_W-1:0]            out_msg_kind,
  output logic                                  out_msg_broadcast,
  output logic [sss_pkg::ROTOR_W-1:0]           out_msg_rotor,
  output logic                                  out_led_on,
  output logic [sss_pkg::PHASE_W-1:0]           out_phase_now
);

  localparam int CUR_W = $clog2(ROTOR_COUNT + 1);
  localparam int IDX_W = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;
  localparam logic [CUR_W-1:0] CUR_END = CUR_W'(ROTOR_COUNT);
  localparam int PAD_W = sss_pkg::DUR_W - sss_pkg::DELAY_W;
  localparam logic [sss_pkg::DUR_W-1:0] ELAPSED_MAX = {sss_pkg::DUR_W{1'b1}};

  // Configuration registers
  logic [sss_pkg::DUR_W-1:0] active_dur_r;
  logic [sss_pkg::DUR_W-1:0] pause_dur_r;

  // Sequencer state
  logic [sss_pkg::PHASE_W-1:0] phase_r, phase_nxt, step_phase;
  logic [sss_pkg::DUR_W-1:0]   elapsed_r, elapsed_nxt, elapsed_inc;
  logic [CUR_W-1:0]            cursor_r, cursor_nxt;
  logic                        done_r, done_nxt;
  logic                        led_r, led_nxt;

  // Delay table memory and its read path
  logic [sss_pkg::DELAY_W-1:0] mem [ROTOR_COUNT];
  logic [ROTOR_COUNT-1:0]      tbl_valid_r;
  logic [sss_pkg::DELAY_W-1:0] mem_q;
  logic                        fwd_r;
  logic [sss_pkg::DELAY_W-1:0] fwd_data_r;
  logic                        rd_vld_r;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic                        tbl_we;
  logic                        wr_in_range;
  logic [sss_pkg::DELAY_W-1:0] delay_cur;

  // Output stage
  sss_pkg::res_t res;
  sss_pkg::res_t out_r, skid_r;
  logic          out_valid_r, skid_valid_r;
  logic          in_acc, out_pop;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_pop  = out_valid_r && !out_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dur_r <= sss_pkg::ACTIVE_DUR_RST;
      pause_dur_r  <= sss_pkg::PAUSE_DUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sss_pkg::CFG_ACTIVE_DUR: active_dur_r <= cfg_wdata;
        sss_pkg::CFG_PAUSE_DUR:  pause_dur_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Delay of the rotor under the cursor: forwarded write, stored entry or reset zero
  assign delay_cur = fwd_r    ? fwd_data_r :
                     rd_vld_r ? mem_q      : '0;

  assign elapsed_inc = (elapsed_r != ELAPSED_MAX) ? elapsed_r + 1'b1 : elapsed_r;
  assign wr_in_range = (32'(in_delay_index) < ROTOR_COUNT);
  assign wr_addr     = IDX_W'(in_delay_index);

  // Phase step for one beat
  always_comb begin
    res         = '0;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    cursor_nxt  = cursor_r;
    done_nxt    = done_r;
    led_nxt     = led_r;
    tbl_we      = 1'b0;
    step_phase  = phase_r;
    if (in_acc) begin
      if (in_op) begin
        tbl_we = wr_in_range;
      end else begin
        if (in_switch_on && phase_r == sss_pkg::PH_OFF) begin
          step_phase = sss_pkg::PH_START_PAUSE;
        end else if (!in_switch_on && phase_r != sss_pkg::PH_OFF) begin
          step_phase = sss_pkg::PH_DEACT;
        end
        phase_nxt = step_phase;
        case (step_phase)
          sss_pkg::PH_OFF: ;
          sss_pkg::PH_DEACT: begin
            res.msg_valid     = 1'b1;
            res.msg_kind      = sss_pkg::KIND_OFF;
            res.msg_broadcast = 1'b1;
            led_nxt           = 1'b0;
            phase_nxt         = sss_pkg::PH_OFF;
          end
          sss_pkg::PH_START_ACTIVE: begin
            led_nxt     = 1'b1;
            done_nxt    = 1'b0;
            elapsed_nxt = '0;
            cursor_nxt  = '0;
            phase_nxt   = sss_pkg::PH_ACTIVE;
          end
          sss_pkg::PH_ACTIVE: begin
            elapsed_nxt = elapsed_inc;
            if (!done_r) begin
              if (cursor_r >= CUR_END) begin
                done_nxt = 1'b1;
              end else if (elapsed_inc > {{PAD_W{1'b0}}, delay_cur}) begin
                res.msg_valid = 1'b1;
                res.msg_kind  = sss_pkg::KIND_START;
                res.msg_rotor = sss_pkg::ROTOR_W'(cursor_r);
                cursor_nxt    = cursor_r + CUR_W'(1);
              end
            end
            if (elapsed_inc > active_dur_r) begin
              phase_nxt = sss_pkg::PH_START_PAUSE;
            end
          end
          sss_pkg::PH_START_PAUSE: begin
            res.msg_valid     = 1'b1;
            res.msg_kind      = sss_pkg::KIND_STOP;
            res.msg_broadcast = 1'b1;
            done_nxt          = 1'b0;
            cursor_nxt        = '0;
            elapsed_nxt       = '0;
            phase_nxt         = sss_pkg::PH_PAUSE;
          end
          sss_pkg::PH_PAUSE: begin
            elapsed_nxt = elapsed_inc;
            if (!done_r) begin
              if (cursor_r >= CUR_END) begin
                done_nxt = 1'b1;
              end else begin
                res.msg_valid = 1'b1;
                res.msg_kind  = sss_pkg::KIND_CONFIG;
                res.msg_rotor = sss_pkg::ROTOR_W'(cursor_r);
                cursor_nxt    = cursor_r + CUR_W'(1);
              end
            end
            if (elapsed_inc > pause_dur_r) begin
              phase_nxt = sss_pkg::PH_START_ACTIVE;
            end
          end
          default: phase_nxt = sss_pkg::PH_DEACT;
        endcase
      end
    end
    res.led_on    = led_nxt;
    res.phase_now = phase_nxt;
  end

  // Prefetch the entry the cursor will point at next cycle
  assign rd_addr = (cursor_nxt >= CUR_END) ? '0 : cursor_nxt[IDX_W-1:0];

  // Delay table storage
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem[wr_addr] <= in_delay_value;
    end
    mem_q      <= mem[rd_addr];
    fwd_data_r <= in_delay_value;
  end

  // Table valid bits and forwarding flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_valid_r <= '0;
      fwd_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_valid_r[wr_addr] <= 1'b1;
      end
      fwd_r    <= tbl_we && (wr_addr == rd_addr);
      rd_vld_r <= tbl_valid_r[rd_addr];
    end
  end

  // Sequencer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sss_pkg::PH_OFF;
      elapsed_r <= '0;
      cursor_r  <= '0;
      done_r    <= 1'b0;
      led_r     <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      cursor_r  <= cursor_nxt;
      done_r    <= done_nxt;
      led_r     <= led_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_msg_valid     = out_r.msg_valid;
  assign out_msg_kind      = out_r.msg_kind;
  assign out_msg_broadcast = out_r.msg_broadcast;
  assign out_msg_rotor     = out_r.msg_rotor;
  assign out_led_on        = out_r.led_on;
  assign out_phase_now     = out_r.phase_now;

  // Skid holds a beat only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full with empty output register");

  // Cursor never passes the end of the table
  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_END)
    else $error("rotor cursor out of range");

  // Unused phase codes are never reached
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= sss_pkg::PH_PAUSE)
    else $error("phase register holds unused code");

  // LED is dark whenever the sequencer is off
  a_led_off: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sss_pkg::PH_OFF) |-> !led_r)
    else $error("LED lit while off");

  // Broadcast results carry rotor zero
  a_bcast_rotor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.msg_broadcast) |-> (out_r.msg_rotor == '0))
    else $error("broadcast beat names a rotor");

endmodule

`default_nettype wire

FILE: tb/rotor_msg_checker.sv
// Result checker for staggered_start_sequencer: follows every accepted beat and register write,
// predicts the rotor message each input beat causes and compares it with the result channel.
// Depends on sss_pkg.
module rotor_msg_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sss_pkg::DUR_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          in_op,
  input  wire logic                          in_switch_on,
  input  wire logic [sss_pkg::ROTOR_W-1:0]   in_delay_index,
  input  wire logic [sss_pkg::DELAY_W-1:0]   in_delay_value,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          out_msg_valid,
  input  wire logic [sss_pkg::KIND_W-1:0]    out_msg_kind,
  input  wire logic                          out_msg_broadcast,
  input  wire logic [sss_pkg::ROTOR_W-1:0]   out_msg_rotor,
  input  wire logic                          out_led_on,
  input  wire logic [sss_pkg::PHASE_W-1:0]   out_phase_now,
  output int                                 mismatches,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam int NROT = ROTOR_COUNT_DEF;

  // Shadow registers and sequencer state
  logic [DUR_W-1:0]   active_dur;
  logic [DUR_W-1:0]   pause_dur;
  logic [PHASE_W-1:0] seq_phase;
  logic [DUR_W-1:0]   elapsed;
  logic [3:0]         cursor;
  logic               done_all;
  logic               led;
  logic [DELAY_W-1:0] delay_tbl [NROT];
  res_t               expected_msgs [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Apply one input beat to the shadow state and return the message it causes
  function automatic res_t advance_sequencer(input logic delay_write, input logic sw,
                                             input logic [ROTOR_W-1:0] idx,
                                             input logic [DELAY_W-1:0] val);
    res_t r;
    r = '0;
    if (delay_write) begin
      if (int'(idx) < NROT) delay_tbl[idx] = val;
    end else begin
      if (sw && seq_phase == PH_OFF) seq_phase = PH_START_PAUSE;
      else if (!sw && seq_phase != PH_OFF) seq_phase = PH_DEACT;

      case (seq_phase)
        PH_OFF: ;
        PH_DEACT: begin
          r.msg_valid     = 1'b1;
          r.msg_kind      = KIND_OFF;
          r.msg_broadcast = 1'b1;
          led             = 1'b0;
          seq_phase       = PH_OFF;
        end
        PH_START_ACTIVE: begin
          led       = 1'b1;
          done_all  = 1'b0;
          elapsed   = '0;
          cursor    = '0;
          seq_phase = PH_ACTIVE;
        end
        PH_ACTIVE: begin
          // advance time first, saturating, then compare
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (!done_all) begin
            if (int'(cursor) >= NROT) begin
              done_all = 1'b1;
            end else if (elapsed > delay_tbl[cursor[ROTOR_W-1:0]]) begin
              r.msg_valid = 1'b1;
              r.msg_kind  = KIND_START;
              r.msg_rotor = cursor[ROTOR_W-1:0];
              cursor      = cursor + 1'b1;
            end
          end
          if (elapsed > active_dur) seq_phase = PH_START_PAUSE;
        end
        PH_START_PAUSE: begin
          r.msg_valid     = 1'b1;
          r.msg_kind      = KIND_STOP;
          r.msg_broadcast = 1'b1;
          done_all        = 1'b0;
          cursor          = '0;
          elapsed         = '0;
          seq_phase       = PH_PAUSE;
        end
        PH_PAUSE: begin
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (!done_all) begin
            if (int'(cursor) >= NROT) begin
              done_all = 1'b1;
            end else begin
              r.msg_valid = 1'b1;
              r.msg_kind  = KIND_CONFIG;
              r.msg_rotor = cursor[ROTOR_W-1:0];
              cursor      = cursor + 1'b1;
            end
          end
          if (elapsed > pause_dur) seq_phase = PH_START_ACTIVE;
        end
        default: seq_phase = PH_DEACT;
      endcase
    end
    r.led_on    = led;
    r.phase_now = seq_phase;
    return r;
  endfunction

  // Track writes and input beats, then match result beats in order
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      active_dur = ACTIVE_DUR_RST;
      pause_dur  = PAUSE_DUR_RST;
      seq_phase  = PH_OFF;
      elapsed    = '0;
      cursor     = '0;
      done_all   = 1'b0;
      led        = 1'b0;
      for (int i = 0; i < NROT; i++) delay_tbl[i] = '0;
      expected_msgs.delete();
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_ACTIVE_DUR: active_dur = cfg_wdata;
          CFG_PAUSE_DUR:  pause_dur  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        expected_msgs.push_back(advance_sequencer(in_op, in_switch_on, in_delay_index,
                                                  in_delay_value));
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = {out_msg_valid, out_msg_kind, out_msg_broadcast, out_msg_rotor,
               out_led_on, out_phase_now};
        if (expected_msgs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: valid=%0d kind=%0d bcast=%0d",
                     $realtime, got.msg_valid, got.msg_kind, got.msg_broadcast,
                     " rotor=%0d led=%0d phase=%0d", got.msg_rotor, got.led_on,
                     got.phase_now);
        end else begin
          want = expected_msgs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  exp valid=%0d kind=%0d bcast=%0d rotor=%0d led=%0d phase=%0d",
                       want.msg_valid, want.msg_kind, want.msg_broadcast, want.msg_rotor,
                       want.led_on, want.phase_now);
              $display("  got valid=%0d kind=%0d bcast=%0d rotor=%0d led=%0d phase=%0d",
                       got.msg_valid, got.msg_kind, got.msg_broadcast, got.msg_rotor,
                       got.led_on, got.phase_now);
            end
          end
        end
      end
    end
    pending = expected_msgs.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the staggered_start_sequencer testbench: clock, reset, register writes, input beats
// and result-side stalls; rotor_msg_checker does the prediction and comparison.
// Depends on sss_pkg, staggered_start_sequencer and rotor_msg_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_DELAY    = 1'b1;
  localparam int   LEG_BEATS   = 190;
  localparam int   HOLD_CYCLES = 400;
  localparam int   QUIET_LIMIT = 2000;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [DUR_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_op          = 1'b0;
  logic                 in_switch_on   = 1'b0;
  logic [ROTOR_W-1:0]   in_delay_index = '0;
  logic [DELAY_W-1:0]   in_delay_value = '0;
  logic                 out_stall      = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_msg_valid;
  logic [KIND_W-1:0]    out_msg_kind;
  logic                 out_msg_broadcast;
  logic [ROTOR_W-1:0]   out_msg_rotor;
  logic                 out_led_on;
  logic [PHASE_W-1:0]   out_phase_now;

  int   mismatches;
  int   pending;
  int   in_idle_pct   = 0;
  int   out_stall_pct = 0;
  int   quiet_cycles  = 0;
  logic hold_active   = 1'b0;

  staggered_start_sequencer DUT (.*);

  rotor_msg_checker msg_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls, or a solid hold-off while one is running
  always @(negedge clk)
    out_stall <= hold_active || ($urandom_range(99) < out_stall_pct);

  // Watchdog: end the run after too long without any beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[staggered_start_sequencer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input beat, with random idle cycles ahead of it, and hold it until taken
  task automatic send_beat(input logic op, input logic sw, input logic [ROTOR_W-1:0] idx,
                           input logic [DELAY_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_switch_on   <= sw;
    in_delay_index <= idx;
    in_delay_value <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_durations(input logic [DUR_W-1:0] act, input logic [DUR_W-1:0] pau);
    drain();
    write_reg(CFG_ACTIVE_DUR, act);
    write_reg(CFG_PAUSE_DUR, pau);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random leg: new durations, an idle pattern, then mostly enabled ticks
  task automatic run_leg(input int leg, input logic [DUR_W-1:0] act,
                         input logic [DUR_W-1:0] pau);
    int                 pick;
    int                 r;
    logic [DELAY_W-1:0] dv;
    set_durations(act, pau);
    case (leg % 4)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 68; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 68; end
      default: begin in_idle_pct = 29; out_stall_pct = 29; end
    endcase
    // fill the block up: hold the result side while beats keep coming
    if (leg == 6) begin
      fork
        begin
          @(posedge clk);
          hold_active = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_active = 1'b0;
        end
      join_none
    end
    repeat (2) send_beat(OP_TICK, 1'b0, 3'($urandom), 16'($urandom));
    for (int i = 0; i < LEG_BEATS; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // delay entry: mostly short so rotors actually start
        r  = $urandom_range(9);
        dv = (r < 7) ? 16'($urandom_range(24)) : (r < 9) ? 16'($urandom) : 16'hFFFF;
        send_beat(OP_DELAY, 1'($urandom), 3'($urandom_range(7)), dv);
      end else begin
        send_beat(OP_TICK, $urandom_range(99) >= 3, 3'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset durations, table extremes, full pause sweep, switch drop
    send_beat(OP_TICK, 1'b0, 3'd0, 16'h0000);
    send_beat(OP_DELAY, 1'b1, 3'd0, 16'h0000);
    send_beat(OP_DELAY, 1'b0, 3'd7, 16'hFFFF);
    send_beat(OP_DELAY, 1'b1, 3'd3, 16'h0002);
    send_beat(OP_TICK, 1'b1, 3'd7, 16'hFFFF);
    repeat (9) send_beat(OP_TICK, 1'b1, 3'd0, 16'h0000);
    send_beat(OP_TICK, 1'b0, 3'd0, 16'h0000);

    // Directed: short phases so the pause ends and rotors start in order
    set_durations(24'd2, 24'd1);
    repeat (9) send_beat(OP_TICK, 1'b1, 3'd0, 16'h0000);

    run_leg(0, 24'd20, 24'd12);
    run_leg(1, 24'd0, 24'd0);
    run_leg(2, 24'hFFFFFF, 24'd3);
    run_leg(3, 24'd40, 24'hFFFFFF);
    run_leg(4, 24'd9, 24'd9);
    run_leg(5, 24'($urandom_range(60)), 24'($urandom_range(30)));
    run_leg(6, 24'd30, 24'd15);
    run_leg(7, 24'($urandom_range(25)), 24'($urandom_range(25)));

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("[staggered_start_sequencer] OK");
    else
      $display("[staggered_start_sequencer] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sss_pkg.sv
rtl/staggered_start_sequencer.sv
tb/rotor_msg_checker.sv
tb/testbench.sv
